FILE: design/day_ordinal_to_calendar_date_core_defines.svh
// Assertion macros for the day ordinal to calendar date RTL.
`ifndef DAY_ORDINAL_TO_CALENDAR_DATE_CORE_DEFINES_SVH
`define DAY_ORDINAL_TO_CALENDAR_DATE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check that is ignored while reset is high.
`define DOTCD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define DOTCD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DOTCD_ASSERT(label, clk, rst, prop, msg)

`define DOTCD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

FILE: design/dotcd_pkg.sv
// Shared types, constants and calendar lookup functions for the date converter.
`default_nettype none

package dotcd_pkg;

   // Pipeline depth: one register stage per step of the conversion.
   localparam int NUM_STAGES = 9;

   // Port field widths.
   localparam int DAY_NUMBER_W    = 23;
   localparam int SECOND_OF_DAY_W = 17;
   localparam int YEAR_W          = 15;
   localparam int MONTH_W         = 4;
   localparam int DAY_W           = 5;
   localparam int HOUR_W          = 5;
   localparam int MINUTE_W        = 6;
   localparam int SECOND_W        = 6;

   // Internal widths: zero-based day offset and unsigned year accumulator.
   localparam int OFFSET_W = 22;
   localparam int YACC_W   = 14;

   // Range limits.
   localparam logic [DAY_NUMBER_W-1:0]    MAX_ORDINAL  = 23'd3652059;
   localparam logic [SECOND_OF_DAY_W-1:0] SECS_PER_DAY = 17'd86400;

   // Days in the 400, 100, 4 and 1 year cycles.
   localparam logic [17:0] DAYS_400Y = 18'd146097;
   localparam logic [15:0] DAYS_100Y = 16'd36524;
   localparam logic [10:0] DAYS_4Y   = 11'd1461;
   localparam logic [8:0]  DAYS_1Y   = 9'd365;

   // Years in the long cycles.
   localparam logic [YACC_W-1:0] YEARS_400 = 14'd400;
   localparam logic [YACC_W-1:0] YEARS_100 = 14'd100;
   localparam logic [YACC_W-1:0] YEARS_4   = 14'd4;

   // Time of day divisors.
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

   // Month estimate: (offset + bias) >> shift, then corrected by at most one.
   localparam logic [9:0]  MONTH_EST_BIAS  = 10'd50;
   localparam int          MONTH_EST_SHIFT = 5;
   localparam logic [MONTH_W-1:0] DECEMBER     = 4'd12;
   localparam logic [MONTH_W-1:0] JANUARY      = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY     = 4'd2;
   localparam logic [DAY_W-1:0]   DAYS_IN_DEC  = 5'd31;

   // Rounded-up reciprocals. With shift = input bits + divisor bits the
   // product's upper bits give the exact quotient for every input value.
   localparam int RECIP400_SHIFT = OFFSET_W + 18;
   localparam longint unsigned RECIP400_FULL =
      ((64'd1 << RECIP400_SHIFT) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y);
   localparam logic [22:0] RECIP400 = 23'(RECIP400_FULL);

   localparam int RECIP4Y_SHIFT = 16 + 11;
   localparam longint unsigned RECIP4Y_FULL =
      ((64'd1 << RECIP4Y_SHIFT) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y);
   localparam logic [16:0] RECIP4Y = 17'(RECIP4Y_FULL);

   localparam int RECIP_HOUR_SHIFT = SECOND_OF_DAY_W + 12;
   localparam longint unsigned RECIP_HOUR_FULL =
      ((64'd1 << RECIP_HOUR_SHIFT) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR);
   localparam logic [17:0] RECIP_HOUR = 18'(RECIP_HOUR_FULL);

   localparam int RECIP_MIN_SHIFT = 12 + 6;
   localparam longint unsigned RECIP_MIN_FULL =
      ((64'd1 << RECIP_MIN_SHIFT) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN);
   localparam logic [12:0] RECIP_MIN = 13'(RECIP_MIN_FULL);

   // One load enable per pipeline stage.
   typedef logic [NUM_STAGES-1:0] stage_vec_type;

   // Time of day carried between the time pipeline and the top level.
   typedef struct packed {
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } tod_type;

   // Days in a common year before the first of the given month.
   function automatic logic [8:0] month_start_day(input logic [MONTH_W-1:0] m);
      logic [8:0] d;
      case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // Length of the given month in a common year.
   function automatic logic [8:0] month_length(input logic [MONTH_W-1:0] m);
      logic [8:0] d;
      case (m)
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd28;
         4'd3:    d = 9'd31;
         4'd4:    d = 9'd30;
         4'd5:    d = 9'd31;
         4'd6:    d = 9'd30;
         4'd7:    d = 9'd31;
         4'd8:    d = 9'd31;
         4'd9:    d = 9'd30;
         4'd10:   d = 9'd31;
         4'd11:   d = 9'd30;
         4'd12:   d = 9'd31;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

FILE: design/day_ordinal_to_calendar_date_core.sv
// Top level of the day ordinal to proleptic Gregorian date and time converter.
`default_nettype none
`include "day_ordinal_to_calendar_date_core_defines.svh"

// The block takes one beat per clock when the result side is not stalled, and
// returns one result beat per input beat, in order. A beat passes through
// the nine register stages of the date path in this order: range check
// and offset, a reciprocal multiply and a remainder stage for the 400 year
// cycle, a compare stage for the 100 year cycle, another multiply and
// remainder pair for the 4 year cycle, a compare stage for single years, then
// month estimate and correction. Each stage holds its beat until the next one
// frees, so bubbles close up and input is taken while a finished result waits.
// A zero or out-of-range ordinal, or a second count of 86400 or more, gives
// rsp_invalid high with all other fields zero.
module day_ordinal_to_calendar_date_core (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic signed [dotcd_pkg::DAY_NUMBER_W-1:0]   req_day_number,
   input  logic [dotcd_pkg::SECOND_OF_DAY_W-1:0]       req_second_of_day,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [dotcd_pkg::YEAR_W-1:0]         rsp_year,
   output logic [dotcd_pkg::MONTH_W-1:0]               rsp_month,
   output logic [dotcd_pkg::DAY_W-1:0]                 rsp_day,
   output logic [dotcd_pkg::HOUR_W-1:0]                rsp_hour,
   output logic [dotcd_pkg::MINUTE_W-1:0]              rsp_minute,
   output logic [dotcd_pkg::SECOND_W-1:0]              rsp_second,
   output logic                                        rsp_invalid
);
   import dotcd_pkg::*;

   localparam int Prod400W = OFFSET_W + $bits(RECIP400);
   localparam int Prod4yW  = 16 + $bits(RECIP4Y);

   // Control.
   stage_vec_type              vld_ff;
   stage_vec_type              stage_en;

   // Flags carried down the pipe: year sign and invalid input.
   logic [NUM_STAGES-2:0]      neg_ff;
   logic [NUM_STAGES-2:0]      bad_ff;

   // Date path registers, named by the stage that loads them.
   logic [OFFSET_W-1:0]        off0_ff, off1_ff;
   logic [4:0]                 q400_ff;
   logic [17:0]                r1_ff;
   logic [YACC_W-1:0]          year2_ff, year3_ff, year4_ff, year5_ff, year6_ff, year7_ff;
   logic [15:0]                r2_ff, r2b_ff;
   logic                       cent_last3_ff, cent_last4_ff, cent_last5_ff;
   logic                       cent_third3_ff, cent_third4_ff, cent_third5_ff;
   logic [4:0]                 q4_ff;
   logic [10:0]                r3_ff;
   logic                       quad_not24_ff;
   logic [8:0]                 r6_ff, r7_ff;
   logic                       special6_ff, special7_ff;
   logic                       leap6_ff, leap7_ff;
   logic [MONTH_W-1:0]         month7_ff;
   logic [8:0]                 prec7_ff;
   logic signed [YEAR_W-1:0]   year_ff;
   logic [MONTH_W-1:0]         month_ff;
   logic [DAY_W-1:0]           day_ff;
   logic                       inv_ff;
   tod_type                    tod;

   // Next values.
   logic [DAY_NUMBER_W-1:0]    raw;
   logic [DAY_NUMBER_W-1:0]    off_in;
   logic                       bad_in;
   logic [Prod400W-1:0]        prod400;
   logic [4:0]                 q400_in;
   logic [17:0]                r1_in;
   logic [YACC_W-1:0]          year2_in, year3_in, year5_in, year6_in;
   logic [2:0]                 n100;
   logic [15:0]                r2_in;
   logic [Prod4yW-1:0]         prod4y;
   logic [4:0]                 q4_in;
   logic [10:0]                r3_in;
   logic [2:0]                 n1;
   logic [8:0]                 r6_in;
   logic [4:0]                 month_est;
   logic [MONTH_W-1:0]         month7_in;
   logic [8:0]                 prec7_in;
   logic [MONTH_W-1:0]         month_in;
   logic [8:0]                 prec_fix;
   logic [DAY_W-1:0]           day_in;
   logic [YACC_W-1:0]          year_fix;
   logic signed [YEAR_W-1:0]   year_in;

   // Stage enables: a stage moves when it is empty or its successor moves.
   always_comb begin
      stage_en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !vld_ff[i] || stage_en[i+1];
      end
   end

   assign req_ready = stage_en[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (stage_en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // Stage 0: zero-based offset of the magnitude and the range checks.
   // For a negative ordinal, magnitude minus one is the bitwise complement.
   // A zero ordinal wraps to all ones and fails the same range check.
   always_comb begin
      raw    = DAY_NUMBER_W'(req_day_number);
      off_in = raw[DAY_NUMBER_W-1] ? ~raw : raw - DAY_NUMBER_W'(1);
      bad_in = (off_in >= MAX_ORDINAL) || (req_second_of_day >= SECS_PER_DAY);
   end

   // Stages 1 to 3: 400 year cycles by reciprocal, then 100 year cycles by compare.
   always_comb begin
      prod400  = Prod400W'(off0_ff) * Prod400W'(RECIP400);
      q400_in  = prod400[RECIP400_SHIFT +: 5];
      r1_in    = 18'(off1_ff - OFFSET_W'(q400_ff) * OFFSET_W'(DAYS_400Y));
      year2_in = YACC_W'(q400_ff) * YEARS_400;
      n100     = 3'd0;
      for (int k = 1; k <= 4; k++) begin
         if (r1_ff >= 18'(k) * 18'(DAYS_100Y)) begin
            n100 = 3'(k);
         end
      end
      r2_in    = 16'(r1_ff - 18'(n100) * 18'(DAYS_100Y));
      year3_in = year2_ff + YACC_W'(n100) * YEARS_100;
   end

   // Stages 4 to 6: 4 year cycles by reciprocal, then single years by compare.
   always_comb begin
      prod4y   = Prod4yW'(r2_ff) * Prod4yW'(RECIP4Y);
      q4_in    = prod4y[RECIP4Y_SHIFT +: 5];
      r3_in    = 11'(r2b_ff - 16'(q4_ff) * 16'(DAYS_4Y));
      year5_in = year4_ff + YACC_W'(q4_ff) * YEARS_4;
      n1       = 3'd0;
      for (int k = 1; k <= 4; k++) begin
         if (r3_ff >= 11'(k) * 11'(DAYS_1Y)) begin
            n1 = 3'(k);
         end
      end
      r6_in    = 9'(r3_ff - 11'(n1) * 11'(DAYS_1Y));
      year6_in = year5_ff + YACC_W'(n1) + YACC_W'(1);
   end

   // Stage 7: month estimate from the day of year, clamped to a real month.
   always_comb begin
      month_est = 5'((10'(r6_ff) + MONTH_EST_BIAS) >> MONTH_EST_SHIFT);
      if (month_est > 5'(DECEMBER)) begin
         month7_in = DECEMBER;
      end else if (month_est < 5'(JANUARY)) begin
         month7_in = JANUARY;
      end else begin
         month7_in = MONTH_W'(month_est);
      end
      prec7_in = month_start_day(month7_in) +
                 9'((month7_in > FEBRUARY) && leap6_ff);
   end

   // Stage 8: step the month back when the estimate overshoots, then the
   // last day of a leap cycle, the year sign and the invalid case.
   always_comb begin
      month_in = month7_ff;
      prec_fix = prec7_ff;
      if ((prec7_ff > r7_ff) && (month7_ff > JANUARY)) begin
         month_in = month7_ff - MONTH_W'(1);
         prec_fix = prec7_ff - month_length(month_in) -
                    9'((month_in == FEBRUARY) && leap7_ff);
      end
      day_in   = DAY_W'(r7_ff - prec_fix + 9'd1);
      year_fix = year7_ff;
      if (special7_ff) begin
         year_fix = year7_ff - YACC_W'(1);
         month_in = DECEMBER;
         day_in   = DAYS_IN_DEC;
      end
      year_in = neg_ff[NUM_STAGES-2] ? -YEAR_W'(year_fix) : YEAR_W'(year_fix);
      if (bad_ff[NUM_STAGES-2]) begin
         year_in  = '0;
         month_in = '0;
         day_in   = '0;
      end
   end

   // Date path stage registers.
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         off0_ff   <= off_in[OFFSET_W-1:0];
         neg_ff[0] <= raw[DAY_NUMBER_W-1];
         bad_ff[0] <= bad_in;
      end
      for (int i = 1; i < NUM_STAGES - 1; i++) begin
         if (stage_en[i]) begin
            neg_ff[i] <= neg_ff[i-1];
         end
      end
      for (int i = 1; i < NUM_STAGES - 1; i++) begin
         if (stage_en[i]) begin
            bad_ff[i] <= bad_ff[i-1];
         end
      end
      if (stage_en[1]) begin
         off1_ff <= off0_ff;
         q400_ff <= q400_in;
      end
      if (stage_en[2]) begin
         r1_ff    <= r1_in;
         year2_ff <= year2_in;
      end
      if (stage_en[3]) begin
         r2_ff          <= r2_in;
         year3_ff       <= year3_in;
         cent_last3_ff  <= (n100 == 3'd4);
         cent_third3_ff <= (n100 == 3'd3);
      end
      if (stage_en[4]) begin
         q4_ff          <= q4_in;
         r2b_ff         <= r2_ff;
         year4_ff       <= year3_ff;
         cent_last4_ff  <= cent_last3_ff;
         cent_third4_ff <= cent_third3_ff;
      end
      if (stage_en[5]) begin
         r3_ff          <= r3_in;
         year5_ff       <= year5_in;
         quad_not24_ff  <= (q4_ff != 5'd24);
         cent_last5_ff  <= cent_last4_ff;
         cent_third5_ff <= cent_third4_ff;
      end
      if (stage_en[6]) begin
         r6_ff       <= r6_in;
         year6_ff    <= year6_in;
         special6_ff <= (n1 == 3'd4) || cent_last5_ff;
         leap6_ff    <= (n1 == 3'd3) && (quad_not24_ff || cent_third5_ff);
      end
      if (stage_en[7]) begin
         r7_ff       <= r6_ff;
         year7_ff    <= year6_ff;
         special7_ff <= special6_ff;
         leap7_ff    <= leap6_ff;
         month7_ff   <= month7_in;
         prec7_ff    <= prec7_in;
      end
      if (stage_en[NUM_STAGES-1]) begin
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         inv_ff   <= bad_ff[NUM_STAGES-2];
      end
   end

   // Time of day runs alongside on the same stage enables.
   dotcd_tod u_tod (
      .clock         (clock),
      .stage_en      (stage_en),
      .second_of_day (req_second_of_day),
      .clear_result  (bad_ff[NUM_STAGES-2]),
      .tod           (tod)
   );

   assign rsp_year    = year_ff;
   assign rsp_month   = month_ff;
   assign rsp_day     = day_ff;
   assign rsp_hour    = tod.hour;
   assign rsp_minute  = tod.minute;
   assign rsp_second  = tod.second;
   assign rsp_invalid = inv_ff;

   // An empty pipe always takes a beat.
   `DOTCD_ASSERT(a_empty_takes_beat, clock, reset, (vld_ff == '0) |-> req_ready, "empty pipeline not ready")
   // A good result carries a real calendar date.
   `DOTCD_ASSERT(a_date_in_range, clock, reset, (rsp_valid && !rsp_invalid) |-> ((rsp_month >= JANUARY) && (rsp_month <= DECEMBER) && (rsp_day >= 5'd1) && (rsp_day <= DAYS_IN_DEC)), "month or day out of range")
   // A good result carries a real time of day.
   `DOTCD_ASSERT(a_time_in_range, clock, reset, (rsp_valid && !rsp_invalid) |-> ((rsp_hour <= 5'd23) && (rsp_minute <= 6'd59) && (rsp_second <= 6'd59)), "time of day out of range")
   // An invalid result has every other field cleared.
   `DOTCD_ASSERT(a_invalid_zero, clock, reset, (rsp_valid && rsp_invalid) |-> ((rsp_year == '0) && (rsp_month == '0) && (rsp_day == '0) && (tod == '0)), "invalid result with nonzero fields")
   // Reset empties the pipe.
   `DOTCD_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

`default_nettype wire

FILE: design/dotcd_tod.sv
// Time of day pipeline: splits a second count into hour, minute and second.
`default_nettype none

module dotcd_tod (
   input  logic                                  clock,
   input  dotcd_pkg::stage_vec_type              stage_en,
   input  logic [dotcd_pkg::SECOND_OF_DAY_W-1:0] second_of_day,
   input  logic                                  clear_result,
   output dotcd_pkg::tod_type                    tod
);
   import dotcd_pkg::*;

   localparam int HourProdW = SECOND_OF_DAY_W + $bits(RECIP_HOUR);
   localparam int MinProdW  = $bits(SECS_PER_HOUR) + $bits(RECIP_MIN);

   logic [SECOND_OF_DAY_W-1:0] secs0_ff, secs1_ff;
   logic [HOUR_W-1:0]          hour1_ff, hour2_ff, hour3_ff;
   logic [11:0]                rem2_ff, rem3_ff;
   logic [MINUTE_W-1:0]        min3_ff;
   tod_type                    dly_ff [4:7];
   tod_type                    out_ff;

   logic [HourProdW-1:0]       hour_prod;
   logic [HOUR_W-1:0]          hour1_in;
   logic [11:0]                rem2_in;
   logic [MinProdW-1:0]        min_prod;
   logic [MINUTE_W-1:0]        min3_in;
   tod_type                    tod4_in;

   // Quotients by reciprocal multiply, remainders by multiply and subtract.
   always_comb begin
      hour_prod = HourProdW'(secs0_ff) * HourProdW'(RECIP_HOUR);
      hour1_in  = hour_prod[RECIP_HOUR_SHIFT +: HOUR_W];
      rem2_in   = 12'(secs1_ff - SECOND_OF_DAY_W'(hour1_ff) * SECOND_OF_DAY_W'(SECS_PER_HOUR));
      min_prod  = MinProdW'(rem2_ff) * MinProdW'(RECIP_MIN);
      min3_in   = min_prod[RECIP_MIN_SHIFT +: MINUTE_W];
      tod4_in.hour   = hour3_ff;
      tod4_in.minute = min3_ff;
      tod4_in.second = SECOND_W'(rem3_ff - 12'(min3_ff) * 12'(SECS_PER_MIN));
   end

   // Stage registers; each stage moves when its enable is high.
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         secs0_ff <= second_of_day;
      end
      if (stage_en[1]) begin
         secs1_ff <= secs0_ff;
         hour1_ff <= hour1_in;
      end
      if (stage_en[2]) begin
         rem2_ff  <= rem2_in;
         hour2_ff <= hour1_ff;
      end
      if (stage_en[3]) begin
         rem3_ff  <= rem2_ff;
         hour3_ff <= hour2_ff;
         min3_ff  <= min3_in;
      end
      if (stage_en[4]) begin
         dly_ff[4] <= tod4_in;
      end
      for (int i = 5; i <= 7; i++) begin
         if (stage_en[i]) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
      if (stage_en[NUM_STAGES-1]) begin
         out_ff <= clear_result ? '0 : dly_ff[7];
      end
   end

   assign tod = out_ff;

endmodule

`default_nettype wire
